// File: src/lpsc_pkg.sv
// ----------------------------------------------------------------------------
// lpsc_pkg
// Shared types and codes for the linear probe symbol counter.
// ----------------------------------------------------------------------------
package lpsc_pkg;

   localparam int SYMBOL_W = 8;
   localparam int COUNT_W  = 32;
   localparam int SLOT_W   = 6;

   localparam logic KIND_COUNT = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef enum logic [2:0] {
      ST_UPDATED  = 3'd0,
      ST_INSERTED = 3'd1,
      ST_IGNORED  = 3'd2,
      ST_FULL     = 3'd3,
      ST_READ     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_PROBE,
      FSM_MATCH,
      FSM_DONE
   } fsm_type;

   // one table entry as held in the memory
   typedef struct packed {
      logic [SYMBOL_W-1:0] key;
      logic [COUNT_W-1:0]  tally;
   } entry_type;

   // memory port strobes from the engine
   typedef struct packed {
      logic rd;
      logic wr;
   } tbl_cmd_type;

   // one result beat
   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot_used;
      logic                occupied;
      logic [SYMBOL_W-1:0] slot_symbol;
      logic [COUNT_W-1:0]  slot_count;
   } result_type;

endpackage

// File: src/lpsc_table.sv
// ----------------------------------------------------------------------------
// lpsc_table
// Slot store: key and tally in a synchronous RAM, occupancy in flip-flops.
// ----------------------------------------------------------------------------
module lpsc_table
   import lpsc_pkg::*;
#(
   parameter int TABLE_SLOTS = 64,
   parameter int IDX_W       = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  tbl_cmd_type      cmd,
   input  logic [IDX_W-1:0] addr,
   input  entry_type        wr_data,
   output entry_type        rd_data,
   output logic             slot_valid
);

   entry_type              mem [TABLE_SLOTS];
   entry_type              rd_data_ff;
   logic [TABLE_SLOTS-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   assign rd_data    = rd_data_ff;
   assign slot_valid = valid_ff[addr];

endmodule

// File: src/lpsc_engine.sv
// ----------------------------------------------------------------------------
// lpsc_engine
// Probe sequencer: walks slots, reads, updates or inserts, builds the result.
// ----------------------------------------------------------------------------
module lpsc_engine
   import lpsc_pkg::*;
#(
   parameter int TABLE_SLOTS = 64,
   parameter int IDX_W       = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   output logic                item_ready,
   input  logic                item_kind,
   input  logic [SYMBOL_W-1:0] item_symbol,
   input  logic [SLOT_W-1:0]   item_slot,
   output logic                res_valid,
   input  logic                res_take,
   output result_type          res,
   output tbl_cmd_type         cmd,
   output logic [IDX_W-1:0]    addr,
   output entry_type           wr_data,
   input  entry_type           rd_data,
   input  logic                slot_valid
);

   typedef logic [IDX_W-1:0] home_tab_type [256];

   // home slot of every byte, built at elaboration by counting round the table
   function automatic home_tab_type home_table();
      home_tab_type t;
      int           r;
      r = 0;
      for (int s = 0; s < 256; s++) begin
         t[s] = IDX_W'(r);
         r++;
         if (r == TABLE_SLOTS) begin
            r = 0;
         end
      end
      return t;
   endfunction

   localparam home_tab_type HOME_TAB = home_table();
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

   fsm_type             state_ff, state_in;
   logic                kind_ff, kind_in;
   logic [SYMBOL_W-1:0] sym_ff, sym_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    n_ff, n_in;
   result_type          res_ff, res_in;
   logic                accept;
   logic                out_of_range;
   logic                key_hit;
   logic [COUNT_W-1:0]  tally_next;

   assign accept       = item_valid && (state_ff == FSM_IDLE);
   assign out_of_range = ({3'b000, item_slot} >= 9'(TABLE_SLOTS));
   assign key_hit      = (rd_data.key == sym_ff);
   assign tally_next   = (rd_data.tally == COUNT_MAX) ? rd_data.tally
                                                      : rd_data.tally + COUNT_ONE;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               if ((item_kind == KIND_READ && out_of_range) ||
                   (item_kind == KIND_COUNT && item_symbol == '0)) begin
                  state_in = FSM_DONE;
               end else begin
                  state_in = FSM_PROBE;
               end
            end
         end
         FSM_PROBE: begin
            state_in = slot_valid ? FSM_MATCH : FSM_DONE;
         end
         FSM_MATCH: begin
            if (kind_ff == KIND_READ || key_hit || n_ff == LAST_SLOT) begin
               state_in = FSM_DONE;
            end else begin
               state_in = FSM_PROBE;
            end
         end
         FSM_DONE: begin
            if (res_take) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      kind_in = kind_ff;
      sym_in  = sym_ff;
      idx_in  = idx_ff;
      n_in    = n_ff;
      res_in  = res_ff;
      cmd     = '0;
      wr_data = '0;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               kind_in = item_kind;
               sym_in  = item_symbol;
               n_in    = '0;
               res_in  = '0;
               if (item_kind == KIND_READ) begin
                  idx_in           = IDX_W'(item_slot);
                  res_in.status    = ST_READ;
                  res_in.slot_used = item_slot;
               end else begin
                  idx_in        = HOME_TAB[item_symbol];
                  res_in.status = ST_IGNORED;
               end
            end
         end
         FSM_PROBE: begin
            res_in           = '0;
            res_in.slot_used = SLOT_W'(idx_ff);
            if (slot_valid) begin
               cmd.rd = 1'b1;
            end else if (kind_ff == KIND_READ) begin
               res_in.status = ST_READ;
            end else begin
               // empty slot ends the probe: claim it
               cmd.wr             = 1'b1;
               wr_data.key        = sym_ff;
               wr_data.tally      = COUNT_ONE;
               res_in.status      = ST_INSERTED;
               res_in.occupied    = 1'b1;
               res_in.slot_symbol = sym_ff;
               res_in.slot_count  = COUNT_ONE;
            end
         end
         FSM_MATCH: begin
            res_in             = '0;
            res_in.slot_used   = SLOT_W'(idx_ff);
            res_in.occupied    = 1'b1;
            res_in.slot_symbol = rd_data.key;
            if (kind_ff == KIND_READ) begin
               res_in.status     = ST_READ;
               res_in.slot_count = rd_data.tally;
            end else if (key_hit) begin
               cmd.wr            = 1'b1;
               wr_data.key       = sym_ff;
               wr_data.tally     = tally_next;
               res_in.status     = ST_UPDATED;
               res_in.slot_count = tally_next;
            end else if (n_ff == LAST_SLOT) begin
               // whole table walked, nothing free
               res_in        = '0;
               res_in.status = ST_FULL;
            end else begin
               n_in   = n_ff + IDX_W'(1);
               idx_in = (idx_ff == LAST_SLOT) ? '0 : idx_ff + IDX_W'(1);
            end
         end
         FSM_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      sym_ff  <= sym_in;
      idx_ff  <= idx_in;
      n_ff    <= n_in;
      res_ff  <= res_in;
   end

   assign addr       = idx_ff;
   assign item_ready = (state_ff == FSM_IDLE);
   assign res_valid  = (state_ff == FSM_DONE);
   assign res        = res_ff;

endmodule

// File: src/linear_probe_symbol_counter_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_symbol_counter_unit
// Byte symbol counter on an open-addressed table with linear probing.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A count beat starts at the symbol's home
// slot (symbol modulo TABLE_SLOTS) and steps slot by slot, wrapping round,
// until it meets its own symbol (count goes up, saturating) or an empty slot
// (symbol inserted with count one). Zero bytes are ignored, and a symbol that
// finds no room is dropped with a table-full status. A read beat returns one
// slot. Items are handled one at a time. Each occupied slot probed takes a
// synchronous RAM read, then compare and write back; a count that ends on an
// empty slot needs no RAM read there. A full table costs the most, as every
// slot is walked. Ignored bytes and out-of-range reads skip the table. The
// result sits in an output register, so the next item is taken while it
// waits. The table starts empty on reset, with no clearing pass.
// ----------------------------------------------------------------------------
module linear_probe_symbol_counter_unit
   import lpsc_pkg::*;
#(
   parameter int TABLE_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] symbol, [13:8] slot_index, [15:14] zero
   input  logic [0:0]  req_tuser,   // [0] kind
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [5:0] slot_used, [6] occupied,
                                    // [14:7] slot_symbol, [46:15] slot_count,
                                    // [47] zero
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

   tbl_cmd_type      cmd;
   logic [IDX_W-1:0] addr;
   entry_type        wr_data;
   entry_type        rd_data;
   logic             slot_valid;
   logic             eng_res_valid;
   result_type       eng_res;
   logic             out_free;
   logic             load;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff, rsp_data_in;

   // slot store
   lpsc_table #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .addr       (addr),
      .wr_data    (wr_data),
      .rd_data    (rd_data),
      .slot_valid (slot_valid)
   );

   // probe sequencer
   lpsc_engine #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .IDX_W       (IDX_W)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (req_tvalid),
      .item_ready  (req_tready),
      .item_kind   (req_tuser[0]),
      .item_symbol (req_tdata[7:0]),
      .item_slot   (req_tdata[13:8]),
      .res_valid   (eng_res_valid),
      .res_take    (out_free),
      .res         (eng_res),
      .cmd         (cmd),
      .addr        (addr),
      .wr_data     (wr_data),
      .rd_data     (rd_data),
      .slot_valid  (slot_valid)
   );

   // output register: free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load     = eng_res_valid && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {1'b0,
                        rsp_data_ff.slot_count,
                        rsp_data_ff.slot_symbol,
                        rsp_data_ff.occupied,
                        rsp_data_ff.slot_used};

endmodule

// File: tb/tb_linear_probe_symbol_counter_unit.sv
// ----------------------------------------------------------------------------
// tb_linear_probe_symbol_counter_unit
// Self-checking bench for the linear probe symbol counter.
// ----------------------------------------------------------------------------
// A short directed run on the empty table covers zero bytes, inserts, updates,
// home-slot collisions, wrap-around at the last slot and reads of empty and
// filled slots. Four random phases follow, with the symbol range widening
// from phase to phase so that the table fills gradually. Each phase uses a
// different mix of sender gaps and receiver stalls. A final sweep offers
// every nonzero byte value, which forces the table full and brings out dropped
// symbols. A read of every slot then follows. A scoreboard keeps its own copy
// of the table and checks each response beat in order against it.
// ----------------------------------------------------------------------------
module tb_linear_probe_symbol_counter_unit;
   import lpsc_pkg::*;

   localparam int TABLE_SLOTS = 64;
   localparam int PHASE_BEATS = 250;
   localparam int SETTLE_CYCLES = 2 * TABLE_SLOTS + 12;   // longest probe plus margin

   // shadow table and queue of slot reports still owed by the block
   class symbol_tally_board;
      bit            in_use   [TABLE_SLOTS];
      logic [7:0]    key_of   [TABLE_SLOTS];
      logic [31:0]   tally_of [TABLE_SLOTS];
      result_type    pending_reports[$];
      int unsigned   mismatches;
      int unsigned   status_seen[5];

      function new();
         foreach (in_use[i]) in_use[i] = 1'b0;
         foreach (status_seen[i]) status_seen[i] = 0;
         mismatches = 0;
      endfunction

      function result_type slot_report(status_type st, int unsigned s);
         result_type r;
         r = '0;
         r.status = st;
         r.slot_used = s[SLOT_W-1:0];
         if (s < TABLE_SLOTS && in_use[s]) begin
            r.occupied    = 1'b1;
            r.slot_symbol = key_of[s];
            r.slot_count  = tally_of[s];
         end
         return r;
      endfunction

      // walks the probe sequence and updates the shadow table
      function result_type tally_lookup(logic kind, logic [7:0] sym, logic [5:0] idx);
         result_type  r;
         int unsigned pos;
         int          n;
         r = '0;
         if (kind == KIND_READ) return slot_report(ST_READ, idx);
         if (sym == 8'd0) begin
            r.status = ST_IGNORED;
            return r;
         end
         pos = sym % TABLE_SLOTS;
         for (n = 0; n < TABLE_SLOTS; n++) begin
            if (!in_use[pos]) begin
               in_use[pos]   = 1'b1;
               key_of[pos]   = sym;
               tally_of[pos] = 32'd1;
               return slot_report(ST_INSERTED, pos);
            end
            if (key_of[pos] == sym) begin
               if (tally_of[pos] != '1) tally_of[pos] = tally_of[pos] + 32'd1;
               return slot_report(ST_UPDATED, pos);
            end
            pos = (pos + 1) % TABLE_SLOTS;
         end
         r.status = ST_FULL;   // no match and no empty slot: symbol dropped
         return r;
      endfunction

      function void note_request(logic kind, logic [7:0] sym, logic [5:0] idx);
         pending_reports.push_back(tally_lookup(kind, sym, idx));
      endfunction

      function void compare_field(string what, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(logic [2:0] st, logic [47:0] d);
         result_type want;
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected response beat, status %0d data %h", $time, st, d);
            mismatches++;
            return;
         end
         want = pending_reports.pop_front();
         compare_field("status", 32'(want.status), 32'(st));
         compare_field("slot_used", 32'(want.slot_used), 32'(d[5:0]));
         compare_field("occupied", 32'(want.occupied), 32'(d[6]));
         compare_field("slot_symbol", 32'(want.slot_symbol), 32'(d[14:7]));
         compare_field("slot_count", want.slot_count, d[46:15]);
         compare_field("pad bit", 32'd0, 32'(d[47]));
         if (st <= ST_READ) status_seen[st]++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   symbol_tally_board board = new();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   linear_probe_symbol_counter_unit #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // response side: check each accepted beat, then pick the next tready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tuser, rsp_tdata);
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // offers one request beat and returns at the edge that accepts it;
   // tvalid stays high afterwards so back-to-back beats need no dead cycle
   task automatic push_item(input logic kind, input logic [7:0] sym, input logic [5:0] idx);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, idx, sym};
      do @(posedge clock); while (!req_tready);
      board.note_request(kind, sym, idx);
   endtask

   task automatic count_symbol(input logic [7:0] sym);
      push_item(KIND_COUNT, sym, 6'($urandom));
   endtask

   task automatic read_slot(input logic [5:0] idx);
      push_item(KIND_READ, 8'($urandom), idx);
   endtask

   // sender holds off until every owed response has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.pending_reports.size() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned send_mix [4] = '{0, 48, 0, 25};
      int unsigned recv_mix [4] = '{0, 0, 48, 25};
      int unsigned sym_limit[4] = '{40, 100, 180, 255};
      int          ph;
      int          i;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed beats on the empty table
      read_slot(6'd0);                       // empty slot reads back zeros
      read_slot(6'd63);
      count_symbol(8'd0);                    // zero byte ignored
      count_symbol(8'd1);                    // insert at home slot
      count_symbol(8'd1);                    // update at home slot
      count_symbol(8'd65);                   // collides with 1, probes on
      count_symbol(8'd129);
      count_symbol(8'd193);
      count_symbol(8'd2);                    // home taken by 65
      count_symbol(8'd65);                   // update away from home slot
      count_symbol(8'd63);                   // last slot
      count_symbol(8'd127);                  // wraps round to slot 0
      count_symbol(8'd255);                  // wraps and walks the run at 0..
      count_symbol(8'd128);
      count_symbol(8'hAA);
      count_symbol(8'h55);
      count_symbol(8'd255);
      push_item(KIND_COUNT, 8'd0, 6'd63);    // zero byte with index bits set
      push_item(KIND_READ, 8'hFF, 6'd63);    // read with symbol bits set
      read_slot(6'd0);
      read_slot(6'd1);
      read_slot(6'd2);
      read_slot(6'd42);
      read_slot(6'd21);
      wait_drained();

      // random phases, widening symbol range, varied gap and stall mix
      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct  = send_mix[ph];
         recv_stall_pct = recv_mix[ph];
         for (i = 0; i < PHASE_BEATS; i++) begin
            if ($urandom_range(0, 99) < 25) read_slot(6'($urandom));
            else count_symbol(8'($urandom_range(0, sym_limit[ph])));
         end
         wait_drained();
      end

      // every nonzero byte value once: the table ends up full and later ones drop
      for (i = 1; i < 256; i++) count_symbol(8'(i));
      for (i = 0; i < TABLE_SLOTS; i++) read_slot(6'(i));
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered: %0d inserts, %0d updates, %0d zero bytes ignored",
               board.status_seen[ST_INSERTED], board.status_seen[ST_UPDATED],
               board.status_seen[ST_IGNORED]);
      $display("         %0d dropped on a full table, %0d slot reads",
               board.status_seen[ST_FULL], board.status_seen[ST_READ]);
      if (board.mismatches == 0 && board.pending_reports.size() == 0) begin
         $display("tb_linear_probe_symbol_counter_unit: done, clean");
      end else begin
         $display("tb_linear_probe_symbol_counter_unit: done, errors");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("timeout waiting on the block");
      $display("tb_linear_probe_symbol_counter_unit: done, errors");
      $finish;
   end

endmodule

// File: linear_probe_symbol_counter_unit.f
src/lpsc_pkg.sv
src/lpsc_table.sv
src/lpsc_engine.sv
src/linear_probe_symbol_counter_unit.sv
tb/tb_linear_probe_symbol_counter_unit.sv
